// ===== src/gait_event_detector_core_assert.svh =====
// Assertion macros for the gait event detector.
// Used by gait_event_detector_core; no other dependencies.
`ifndef GAIT_EVENT_DETECTOR_CORE_ASSERT_SVH
`define GAIT_EVENT_DETECTOR_CORE_ASSERT_SVH
`define GED_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GED_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== src/ged_pkg.sv =====
// Shared types and constants for the gait event detector.
// No dependencies.
package ged_pkg;
    localparam int WINDOW_DEPTH = 15;
    localparam int RATE_BITS    = 16;

    localparam logic [2:0] CLS_NONE  = 3'd0;
    localparam logic [2:0] CLS_STILL = 3'd1;
    localparam logic [2:0] CLS_TRANS = 3'd2;
    localparam logic [2:0] CLS_LEVEL = 3'd3;
    localparam logic [2:0] CLS_DOWN  = 3'd4;
    localparam logic [2:0] CLS_UP    = 3'd5;

    localparam logic [2:0] REG_PASS   = 3'd0;
    localparam logic [2:0] REG_SWING  = 3'd1;
    localparam logic [2:0] REG_DOWN   = 3'd2;
    localparam logic [2:0] REG_LEVEL  = 3'd3;
    localparam logic [2:0] REG_UP     = 3'd4;
    localparam logic [2:0] REG_SPREAD = 3'd5;
    localparam logic [2:0] REG_FLOOR  = 3'd6;

    localparam int CROSS_MS = 40;
    localparam int PEAK_MS  = 180;
    localparam int TOE_MS   = 210;

    // min/max travelling down the cell chain
    typedef struct packed {
        logic valid;
        logic signed [31:0] mx;
        logic signed [31:0] mn;
    } t_span;
endpackage

// ===== src/ged_cell.sv =====
// One window cell: holds a sample, shifts it on, folds it into the span.
// Depends on ged_pkg.
module ged_cell #(
    parameter int RATE_BITS = ged_pkg::RATE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic                        i_sweep,
    input  logic signed [RATE_BITS-1:0] i_data,
    input  logic                        i_data_vld,
    input  ged_pkg::t_span              i_span,
    output logic signed [RATE_BITS-1:0] o_data,
    output logic                        o_data_vld,
    output ged_pkg::t_span              o_span
);
    logic signed [RATE_BITS-1:0] r_data;
    logic                        r_vld;
    ged_pkg::t_span              r_span, n_span;
    logic signed [31:0]          w_v;

    assign w_v = 32'(r_data);

    always_comb begin
        n_span = i_span;
        if (r_vld) begin
            if (!i_span.valid) begin
                n_span.valid = 1'b1;
                n_span.mx = w_v;
                n_span.mn = w_v;
            end else begin
                if (w_v > i_span.mx) n_span.mx = w_v;
                if (w_v < i_span.mn) n_span.mn = w_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_span.valid <= 1'b0;
        end else begin
            if (i_shift) begin
                r_data <= i_data;
                r_vld  <= i_data_vld;
            end
            if (i_sweep) r_span <= n_span;
            else r_span.valid <= 1'b0;
        end
    end

    assign o_data     = r_data;
    assign o_data_vld = r_vld;
    assign o_span     = r_span;
endmodule

// ===== src/gait_event_detector_core.sv =====
// Gait event detector: one result per shank rate sample. A sample is taken,
// the events are decided at once, then the stationary span ripples through the
// chain of WINDOW_DEPTH window cells, one cell a cycle, in the sweep state
// between accept and result load; no new sample is taken until the result is
// loaded. A result not yet taken holds the next sample in the result stage.
// No clearing pass after reset.
// Depends on ged_pkg, ged_cell and gait_event_detector_core_assert.svh.
`include "gait_event_detector_core_assert.svh"
module gait_event_detector_core #(
    parameter int WINDOW_DEPTH = ged_pkg::WINDOW_DEPTH,
    parameter int RATE_BITS    = ged_pkg::RATE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [RATE_BITS-1:0] rate_sample, [RATE_BITS+15:RATE_BITS] elapsed_ms, zero pad
    input  logic [((RATE_BITS+16+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // 0 heel_strike, 1 zero_cross, 2 lambda_peak, 3 toe_off, 4 mid_swing,
    // 7:5 gait_class
    output logic [7:0]  m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data
);
    localparam int CW = $clog2(WINDOW_DEPTH + 2);
    localparam logic [1:0] ST_IDLE = 2'd0, ST_SWEEP = 2'd1, ST_OUT = 2'd2;

    logic [1:0] r_st;
    logic [CW-1:0] r_cnt;
    logic signed [15:0] r_pass, r_swth, r_lvl, r_uprt, r_floor;
    logic signed [16:0] r_dni;
    logic [15:0] r_spread;

    logic signed [RATE_BITS-1:0] r_p, r_pp, r_srate;
    logic [7:0]  r_cc;
    logic [3:0]  r_arm;
    logic [15:0] r_st_t, r_sw_t, r_pk_t;
    logic signed [16:0] r_gap;
    logic [2:0]  r_cls, r_cls_b, r_evcls;
    logic [4:0]  r_ev;
    logic [7:0]  r_out;
    logic        r_ovld;

    logic acc;
    logic out_go;
    logic signed [RATE_BITS-1:0] w;
    logic [15:0] now;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign w   = s_axis_tdata[RATE_BITS-1:0];
    assign now = s_axis_tdata[RATE_BITS+15:RATE_BITS];
    assign s_axis_tready = (r_st == ST_IDLE);
    // result stage loads once the previous result is gone or leaving
    assign out_go = (r_st == ST_OUT) && (!r_ovld || m_axis_tready);

    // event logic on the accepted sample
    logic [7:0] n_cc;
    logic [3:0] n_arm;
    logic [2:0] n_cls;
    logic [4:0] ev;
    logic signed [RATE_BITS-1:0] n_srate;
    logic signed [16:0] n_gap;
    logic [15:0] n_st_t, n_sw_t, n_pk_t;
    logic signed [17:0] d_st, d_pk;
    logic signed [RATE_BITS+4:0] a5, b4, a10, b9;
    logic signed [31:0] wx, px, ppx, thx;
    logic [8:0] ccx;

    always_comb begin
        wx = 32'(w); px = 32'(r_p); ppx = 32'(r_pp); thx = 32'(r_pass);
        ccx = {1'b0, r_cc};
        if (wx >= thx && px <= thx) ccx = ccx + 9'd1;
        if (wx <= thx && px >= thx) ccx = ccx + 9'd1;
        n_cc = (ccx > 9'd255) ? 8'd255 : ccx[7:0];
        n_arm = r_arm; n_cls = r_cls; ev = '0;
        n_srate = r_srate; n_gap = r_gap;
        n_st_t = r_st_t; n_sw_t = r_sw_t; n_pk_t = r_pk_t;
        if (r_p <= r_pp && r_p <= w && r_p < 0 && n_cc != 0 && !n_cc[0]) begin
            n_st_t = now; n_cc = '0; n_arm = n_arm | 4'b0111;
            n_srate = r_p;
            n_gap = $signed({1'b0, now}) - $signed({1'b0, r_sw_t});
            ev[0] = 1'b1;
        end
        d_st = $signed({2'b0, now}) - $signed({2'b0, n_st_t});
        if (r_p < 0 && w > 0 && n_arm[2] && d_st > 18'(ged_pkg::CROSS_MS)) begin
            n_arm[2] = 1'b0; ev[1] = 1'b1;
        end
        a5 = (RATE_BITS+5)'(r_pp) * (RATE_BITS+5)'(5);
        b4 = (RATE_BITS+5)'(n_srate) * (RATE_BITS+5)'(4);
        if (r_p >= r_pp && r_p >= w && a5 > b4 && ppx < thx && n_arm[0] &&
            d_st > 18'(ged_pkg::PEAK_MS)) begin
            n_pk_t = now; n_arm[0] = 1'b0; n_arm[2] = 1'b0; n_arm[3] = 1'b1;
            ev[2] = 1'b1;
            if (wx > 32'(r_uprt)) n_cls = ged_pkg::CLS_UP;
            if (n_gap > r_dni) n_cls = ged_pkg::CLS_DOWN;
            else if (w < 0) begin
                if (r_cls_b == ged_pkg::CLS_UP || r_cls_b == ged_pkg::CLS_DOWN ||
                    r_cls_b == ged_pkg::CLS_STILL) n_cls = ged_pkg::CLS_TRANS;
                if (32'(n_srate) < 32'(r_lvl)) n_cls = ged_pkg::CLS_LEVEL;
            end
        end
        d_pk = $signed({2'b0, now}) - $signed({2'b0, n_pk_t});
        a10 = (RATE_BITS+5)'(r_p) * (RATE_BITS+5)'(10);
        b9  = (RATE_BITS+5)'(n_srate) * (RATE_BITS+5)'(9);
        if (r_p <= r_pp && r_p <= w && a10 < b9 && n_arm[3] &&
            d_pk > 18'(ged_pkg::TOE_MS)) begin
            n_arm[3] = 1'b0; n_arm[1] = 1'b1; ev[3] = 1'b1;
        end
        if (r_p >= r_pp && r_p >= w && px > 32'(r_swth) && n_arm[1]) begin
            n_sw_t = now; n_arm[1] = 1'b0; ev[4] = 1'b1;
        end
    end

    // window cell chain
    ged_pkg::t_span sp [WINDOW_DEPTH+1];
    logic signed [RATE_BITS-1:0] dd [WINDOW_DEPTH+1];
    logic dv [WINDOW_DEPTH+1];
    logic sweep;
    assign sweep = (r_st == ST_SWEEP);
    assign dd[0] = w;
    assign dv[0] = 1'b1;
    assign sp[0] = '{valid: 1'b0, mx: 32'sd0, mn: 32'sd0};
    genvar g;
    generate
        for (g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
            ged_cell #(.RATE_BITS(RATE_BITS)) u_cell (
                .i_clk, .i_rst_n, .i_shift(acc), .i_sweep(sweep),
                .i_data(dd[g]), .i_data_vld(dv[g]), .i_span(sp[g]),
                .o_data(dd[g+1]), .o_data_vld(dv[g+1]), .o_span(sp[g+1])
            );
        end
    endgenerate

    ged_pkg::t_span fin;
    logic [2:0] fcls;
    logic signed [32:0] spr;
    assign fin = sp[WINDOW_DEPTH];
    always_comb begin
        spr = 33'(fin.mx) - 33'(fin.mn);
        fcls = r_evcls;
        if (spr <= 33'($signed({1'b0, r_spread})) && fin.mn > 32'(r_floor))
            fcls = ged_pkg::CLS_STILL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= 16'sd1442; r_swth <= 16'sd1442; r_dni <= '0; r_lvl <= '0;
            r_uprt <= 16'sd100; r_spread <= 16'd48; r_floor <= -16'sd128;
            r_st <= ST_IDLE; r_cnt <= '0; r_ovld <= 1'b0;
            r_p <= '0; r_pp <= '0; r_srate <= '0; r_cc <= '0; r_arm <= '0;
            r_st_t <= '0; r_sw_t <= '0; r_pk_t <= '0; r_gap <= '0;
            r_cls <= '0; r_cls_b <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ged_pkg::REG_PASS:   r_pass   <= i_cfg_data[15:0];
                    ged_pkg::REG_SWING:  r_swth   <= i_cfg_data[15:0];
                    ged_pkg::REG_DOWN:   r_dni    <= i_cfg_data;
                    ged_pkg::REG_LEVEL:  r_lvl    <= i_cfg_data[15:0];
                    ged_pkg::REG_UP:     r_uprt   <= i_cfg_data[15:0];
                    ged_pkg::REG_SPREAD: r_spread <= i_cfg_data[15:0];
                    ged_pkg::REG_FLOOR:  r_floor  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_go) r_ovld <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovld <= 1'b0;
            unique case (r_st)
                ST_IDLE: if (acc) begin
                    r_st <= ST_SWEEP; r_cnt <= '0;
                    r_p <= w; r_pp <= r_p; r_srate <= n_srate; r_cc <= n_cc;
                    r_arm <= n_arm; r_st_t <= n_st_t; r_sw_t <= n_sw_t;
                    r_pk_t <= n_pk_t; r_gap <= n_gap;
                end
                ST_SWEEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(WINDOW_DEPTH)) r_st <= ST_OUT;
                end
                ST_OUT: if (out_go) begin
                    r_st <= ST_IDLE;
                    r_cls <= fcls; r_cls_b <= fcls;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
        if (acc) begin r_ev <= ev; r_evcls <= n_cls; end
        if (out_go) r_out <= {fcls, r_ev};
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_out;

    `GED_ASSERT(a_no_acc_busy, i_clk, i_rst_n, (r_st != ST_IDLE) |-> !s_axis_tready, "accept while busy")
    `GED_ASSERT(a_out_after, i_clk, i_rst_n, $rose(r_ovld) |-> $past(r_st) == ST_OUT, "stray result")
    `GED_ASSERT(a_cls_range, i_clk, i_rst_n, r_ovld |-> r_out[7:5] <= ged_pkg::CLS_UP, "bad class")
    `GED_ASSERT_RST(a_rst, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
endmodule
